[rtl/led_matrix_frame_flusher_defines.svh]
// assertion macros for the led matrix frame flusher
// used by the top level only; depends on a clock named clk and a reset named rst_n
`ifndef LED_MATRIX_FRAME_FLUSHER_DEFINES_SVH
`define LED_MATRIX_FRAME_FLUSHER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LMFF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmff assertion failed");

// antecedent implies consequent in the next cycle
`define LMFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmff assertion failed");

`else

`define LMFF_ASSERT_NOW(label, ante, cons)
`define LMFF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/lmff_pkg.sv]
// shared types, constants and codes for the led matrix frame flusher
// no dependencies; imported by the controller, the datapath, the top level and the testbench
package lmff_pkg;

  // geometry of the driver chips and the panel
  localparam int CHIPS  = 2;
  localparam int WIDTH  = 32;
  localparam int HEIGHT = 12;
  localparam int DOTS   = 192;

  // frame store sizing
  localparam int DEPTH  = CHIPS * DOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(WIDTH * HEIGHT);

  // bits needed to pick one dirty flag
  localparam int CHIP_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;

  // bus bytes
  localparam logic [7:0] BYTE_PAGE_CMD  = 8'hfd;
  localparam logic [7:0] BYTE_UNLOCK    = 8'hfe;
  localparam logic [7:0] BYTE_UNLOCK_KEY = 8'hc5;
  localparam logic [7:0] BYTE_PAGE_PWM  = 8'h01;
  localparam logic [7:0] BYTE_PAGE_FUNC = 8'h03;
  localparam logic [7:0] BYTE_PWM_START = 8'h00;
  localparam logic [7:0] BYTE_CURRENT   = 8'h01;

  // item modes
  typedef enum logic [2:0] {
    MODE_SET_PIXEL = 3'd0,
    MODE_CLEAR     = 3'd1,
    MODE_FILL      = 3'd2,
    MODE_FLUSH     = 3'd3,
    MODE_BRIGHT    = 3'd4,
    MODE_NEXT_BYTE = 3'd5
  } mode_t;

  // byte sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_F_UNLOCK = 3'd1,
    PH_F_PAGE   = 3'd2,
    PH_F_DATA   = 3'd3,
    PH_B_UNLOCK = 3'd4,
    PH_B_PAGE   = 3'd5,
    PH_B_CURR   = 3'd6
  } phase_t;

  // controller states
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PIX_WR,
    ST_EMIT
  } ctrl_state_t;

  // input word
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
    logic [7:0] level;
  } in_t;

  // result word
  typedef struct packed {
    logic       idle;
    logic [1:0] chip_index;
    logic [7:0] out_byte;
    logic       first;
    logic       last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pix_wr;
    logic sweep_wr;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_busy;
  } ctrl_stat_t;

endpackage

[rtl/lmff_ctrl.sv]
// controller state machine: accepts input words and sequences store sweeps,
// pixel writes and byte emission; depends on lmff_pkg
module lmff_ctrl
  import lmff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_mode,
  input  ctrl_stat_t stat,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_mode)
            MODE_SET_PIXEL: state_nxt = ST_PIX_WR;
            MODE_CLEAR:     state_nxt = ST_SWEEP;
            MODE_FILL:      state_nxt = ST_SWEEP;
            MODE_NEXT_BYTE: state_nxt = ST_EMIT;
            default:        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/lmff_dpath.sv]
// datapath: frame store memory, dirty flags, brightness state, byte sequencer
// registers and the output register; depends on lmff_pkg
module lmff_dpath
  import lmff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  input  in_t        in_data,
  input  logic       out_stall,
  output ctrl_stat_t stat,
  output logic       out_valid,
  output out_t       out_data
);

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } pick_t;

  // first dirty chip at or after start
  function automatic pick_t find_dirty(input logic [CHIPS-1:0] d, input logic [2:0] start);
    pick_t p;
    p = '0;
    for (int c = CHIPS - 1; c >= 0; c--) begin
      if ((c >= int'(start)) && d[c]) begin
        p.found = 1'b1;
        p.idx   = 2'(c);
      end
    end
    return p;
  endfunction

  // chip that holds a given frame index
  function automatic logic [1:0] chip_of(input logic [IDX_W-1:0] idx);
    logic [1:0] ch;
    ch = '0;
    for (int c = 1; c < CHIPS; c++) begin
      if (int'(idx) >= c * DOTS) begin
        ch = 2'(c);
      end
    end
    return ch;
  endfunction

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  logic [ADDR_W-1:0] sweep_cnt_r;
  logic [7:0]        fill_val_r;

  logic [ADDR_W-1:0] pix_addr_r;
  logic [1:0]        pix_chip_r;
  logic              pix_ok_r;
  logic              pix_on_r;
  logic [7:0]        pix_value;
  logic              pix_change;

  logic [CHIPS-1:0]  dirty_r, dirty_nxt;
  logic [7:0]        on_level_r, on_level_nxt;
  logic [7:0]        bright_val_r, bright_val_nxt;
  logic              flush_pend_r, flush_pend_nxt;
  logic              bright_pend_r, bright_pend_nxt;
  phase_t            phase_r, phase_nxt;
  logic [1:0]        chip_r, chip_nxt;
  logic [7:0]        count_r, count_nxt;

  logic              out_valid_r;
  out_t              out_r, res;

  logic [IDX_W-1:0]  pix_idx;
  logic              pix_ok;
  logic [7:0]        seq_k;
  logic [ADDR_W-1:0] seq_addr;
  logic              is_set_pixel;

  // pixel address decode
  assign pix_idx      = IDX_W'(in_data.y) * IDX_W'(WIDTH) + IDX_W'(in_data.x);
  assign pix_ok       = (int'(in_data.x) < WIDTH) && (int'(in_data.y) < HEIGHT) &&
                        (int'(pix_idx) < DEPTH);
  assign is_set_pixel = cmd.accept && (in_data.mode == MODE_SET_PIXEL);

  // store address of the next pwm byte, clamped to the last dot
  assign seq_k    = (count_r - 8'd1 >= 8'(DOTS)) ? 8'(DOTS - 1) : count_r - 8'd1;
  assign seq_addr = ADDR_W'(int'(chip_r) * DOTS + int'(seq_k));

  assign rd_addr  = is_set_pixel ? ADDR_W'(pix_idx) : seq_addr;

  // pixel write value and change test
  assign pix_value  = pix_on_r ? on_level_r : 8'd0;
  assign pix_change = pix_ok_r && (rd_data_r != pix_value);

  // frame store, registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (cmd.sweep_wr) begin
      mem[sweep_cnt_r] <= fill_val_r;
    end else if (cmd.pix_wr && pix_change) begin
      mem[pix_addr_r] <= pix_value;
    end
  end

  // latched pixel request
  always_ff @(posedge clk) begin
    if (is_set_pixel) begin
      pix_addr_r <= ADDR_W'(pix_idx);
      pix_chip_r <= chip_of(pix_idx);
      pix_ok_r   <= pix_ok;
      pix_on_r   <= in_data.on;
    end
  end

  // item updates and byte sequencer
  always_comb begin
    pick_t      pk;
    phase_t     ph;
    logic [1:0] ch;
    logic [7:0] cn;
    logic       go;
    logic [7:0] pa;
    logic [7:0] pb;
    phase_t     pend;

    dirty_nxt       = dirty_r;
    on_level_nxt    = on_level_r;
    bright_val_nxt  = bright_val_r;
    flush_pend_nxt  = flush_pend_r;
    bright_pend_nxt = bright_pend_r;
    phase_nxt       = phase_r;
    chip_nxt        = chip_r;
    count_nxt       = count_r;
    res             = '0;
    pk              = '0;
    ph              = phase_r;
    ch              = chip_r;
    cn              = count_r;
    go              = 1'b1;
    pa              = BYTE_UNLOCK;
    pb              = BYTE_UNLOCK_KEY;
    pend            = PH_IDLE;

    // accepted words other than a byte request
    if (cmd.accept) begin
      case (in_data.mode)
        MODE_CLEAR, MODE_FILL: begin
          dirty_nxt = '1;
        end
        MODE_FLUSH: begin
          flush_pend_nxt = 1'b1;
        end
        MODE_BRIGHT: begin
          on_level_nxt    = (in_data.level == 8'd0) ? 8'd1 : in_data.level;
          bright_val_nxt  = in_data.level;
          bright_pend_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // dirty mark from a pixel that changed
    if (cmd.pix_wr && pix_change) begin
      dirty_nxt[pix_chip_r[CHIP_W-1:0]] = 1'b1;
    end

    if (cmd.emit) begin
      // no sequence running: brightness pass first, then a flush pass
      if (!(ph == PH_F_UNLOCK || ph == PH_F_PAGE || ph == PH_F_DATA ||
            ph == PH_B_UNLOCK || ph == PH_B_PAGE || ph == PH_B_CURR)) begin
        ph = PH_IDLE;
        if (bright_pend_r) begin
          bright_pend_nxt = 1'b0;
          ph = PH_B_UNLOCK;
          ch = '0;
          cn = '0;
        end else if (flush_pend_r) begin
          flush_pend_nxt = 1'b0;
          pk = find_dirty(dirty_r, 3'd0);
          ch = '0;
          cn = '0;
          if (pk.found) begin
            dirty_nxt[pk.idx[CHIP_W-1:0]] = 1'b0;
            ph = PH_F_UNLOCK;
            ch = pk.idx;
          end
        end
        if (ph == PH_IDLE) begin
          res.idle  = 1'b1;
          go        = 1'b0;
          phase_nxt = PH_IDLE;
          chip_nxt  = ch;
          count_nxt = cn;
        end
      end

      if (go) begin
        chip_nxt       = ch;
        res.chip_index = ch;
        // pick bytes and follow-on phase for the two-byte transactions
        case (ph)
          PH_F_UNLOCK: begin
            pa = BYTE_UNLOCK;    pb = BYTE_UNLOCK_KEY; pend = PH_F_PAGE;
          end
          PH_F_PAGE: begin
            pa = BYTE_PAGE_CMD;  pb = BYTE_PAGE_PWM;   pend = PH_F_DATA;
          end
          PH_B_UNLOCK: begin
            pa = BYTE_UNLOCK;    pb = BYTE_UNLOCK_KEY; pend = PH_B_PAGE;
          end
          PH_B_PAGE: begin
            pa = BYTE_PAGE_CMD;  pb = BYTE_PAGE_FUNC;  pend = PH_B_CURR;
          end
          default: begin
            pa = BYTE_CURRENT;   pb = bright_val_r;    pend = PH_B_UNLOCK;
          end
        endcase

        if (ph == PH_F_DATA) begin
          // pwm transaction: start byte then every dot of the chip
          if (cn == 8'd0) begin
            res.out_byte = BYTE_PWM_START;
            res.first    = 1'b1;
            count_nxt    = 8'd1;
            phase_nxt    = ph;
          end else begin
            res.out_byte = rd_data_r;
            phase_nxt    = ph;
            if (cn >= 8'(DOTS)) begin
              res.last  = 1'b1;
              pk        = find_dirty(dirty_r, {1'b0, ch} + 3'd1);
              chip_nxt  = '0;
              count_nxt = '0;
              phase_nxt = PH_IDLE;
              if (pk.found) begin
                dirty_nxt[pk.idx[CHIP_W-1:0]] = 1'b0;
                phase_nxt = PH_F_UNLOCK;
                chip_nxt  = pk.idx;
              end
            end else begin
              count_nxt = cn + 8'd1;
            end
          end
        end else if (cn == 8'd0) begin
          res.out_byte = pa;
          res.first    = 1'b1;
          count_nxt    = 8'd1;
          phase_nxt    = ph;
        end else begin
          res.out_byte = pb;
          res.last     = 1'b1;
          count_nxt    = 8'd0;
          phase_nxt    = pend;
          // current write closes one chip of the brightness pass
          if (ph == PH_B_CURR) begin
            if ({1'b0, ch} + 3'd1 < 3'(CHIPS)) begin
              chip_nxt  = ch + 2'd1;
              phase_nxt = PH_B_UNLOCK;
            end else begin
              chip_nxt  = '0;
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r   <= '0;
      fill_val_r    <= '0;
      dirty_r       <= '0;
      on_level_r    <= 8'hff;
      bright_val_r  <= '0;
      flush_pend_r  <= 1'b0;
      bright_pend_r <= 1'b0;
      phase_r       <= PH_IDLE;
      chip_r        <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      dirty_r       <= dirty_nxt;
      on_level_r    <= on_level_nxt;
      bright_val_r  <= bright_val_nxt;
      flush_pend_r  <= flush_pend_nxt;
      bright_pend_r <= bright_pend_nxt;
      phase_r       <= phase_nxt;
      chip_r        <= chip_nxt;
      count_r       <= count_nxt;

      // sweep address and fill value
      if (cmd.accept && (in_data.mode == MODE_CLEAR || in_data.mode == MODE_FILL)) begin
        sweep_cnt_r <= '0;
        fill_val_r  <= (in_data.mode == MODE_FILL && in_data.on) ? on_level_r : 8'd0;
      end else if (cmd.sweep_wr) begin
        sweep_cnt_r <= stat.sweep_last ? '0 : sweep_cnt_r + 1'b1;
      end

      // output word handshake
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res;
    end
  end

  assign stat.sweep_last = (sweep_cnt_r == ADDR_W'(DEPTH - 1));
  assign stat.out_busy   = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

[rtl/led_matrix_frame_flusher.sv]
// led matrix frame flusher, top level; depends on lmff_pkg, lmff_ctrl, lmff_dpath
// and led_matrix_frame_flusher_defines.svh. Keeps the pwm frame of the driver
// chips with a dirty flag per chip and hands out the serial bus byte stream one
// byte per next-byte word. Words are taken one at a time: flush, brightness and
// unused modes are done in the accepting state, a pixel write goes through the
// store read, then compare and write, a next-byte word waits in the emit state
// while the previous result waits at the output register, and clear or fill
// sweep all 384 entries of the frame store one entry a cycle, as it has one
// write port. After reset the same sweep clears the store, so no word is taken until it is done.
`include "led_matrix_frame_flusher_defines.svh"

module led_matrix_frame_flusher
  import lmff_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // controller
  lmff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath
  lmff_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // checks
  `LMFF_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.accept, cmd.pix_wr, cmd.sweep_wr, cmd.emit}))
  `LMFF_ASSERT_NOW(a_emit_free, cmd.emit, !(out_valid && out_stall))
  `LMFF_ASSERT_NOW(a_idle_word, out_valid && out_data.idle, out_data.out_byte == 8'd0 && !out_data.first && !out_data.last && out_data.chip_index == 2'd0)
  `LMFF_ASSERT_NEXT(a_nb_busy, in_valid && !in_stall && in_data.mode == MODE_NEXT_BYTE, in_stall)

endmodule

[tb/tb.sv]
// self-checking testbench for led_matrix_frame_flusher
// depends on lmff_pkg and the rtl top level; predicts every bus byte and compares
`timescale 1ns / 1ps

module tb;
  import lmff_pkg::*;

  localparam int          CLK_HIGH     = 4;
  localparam int          CLK_LOW      = 4;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int          N_RANDOM     = 1950;
  localparam int          DRAIN_CYCLES = 400;
  localparam int          LONG_HOLD    = 300;
  localparam int          MAX_PRINTS   = 40;

  // modes the block ignores
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam out_t IDLE_ANSWER = {1'b1, 2'd0, 8'h00, 1'b0, 1'b0};
  localparam out_t NO_ANSWER   = '0;

  typedef struct packed {
    in_t  w;
    logic typed;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  led_matrix_frame_flusher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // predicted frame store and sequencer
  logic [7:0]  frame_q [DEPTH];
  logic        dirty_q [CHIPS];
  logic [7:0]  lit_level;
  logic        flush_armed;
  logic        bright_armed;
  logic [7:0]  bright_lvl;
  phase_t      seq_ph;
  int unsigned seq_ch;
  int unsigned seq_cnt;

  out_t        pending_bytes [$];
  stim_row_t   stim_tab [$];

  int unsigned cycle_cnt = 0;
  int          error_cnt = 0;
  int          words_sent = 0;
  int          bytes_seen = 0;
  int          idle_seen = 0;
  int          pwm_bytes = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_left = 0;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  task automatic report(input string msg);
    if (error_cnt < MAX_PRINTS) $display("[cycle %0d] mismatch: %s", cycle_cnt, msg);
    error_cnt++;
  endtask

  // first dirty chip at or after start begins its transfer
  function automatic void start_dirty(input int unsigned start);
    for (int unsigned c = start; c < CHIPS; c++) begin
      if (dirty_q[c]) begin
        dirty_q[c] = 1'b0;
        seq_ch     = c;
        seq_ph     = PH_F_UNLOCK;
        seq_cnt    = 0;
        return;
      end
    end
    seq_ph  = PH_IDLE;
    seq_ch  = 0;
    seq_cnt = 0;
  endfunction

  // two-byte transaction, returns 1 on its second byte
  function automatic logic pair_byte(input logic [7:0] a, input logic [7:0] b,
                                     output logic [7:0] bt, output logic fst,
                                     output logic lst);
    if (seq_cnt == 0) begin
      bt = a; fst = 1'b1; lst = 1'b0;
      seq_cnt = 1;
      return 1'b0;
    end
    bt = b; fst = 1'b0; lst = 1'b1;
    seq_cnt = 0;
    return 1'b1;
  endfunction

  // applies one accepted word to the predicted state, queues any bus byte
  function automatic void apply_word(input in_t w);
    out_t        r;
    int unsigned idx;
    int unsigned ch;
    logic [7:0]  val;
    logic        done;
    r = NO_ANSWER;
    case (w.mode)
      MODE_SET_PIXEL: begin
        if (w.x >= WIDTH || w.y >= HEIGHT) return;
        idx = w.y * WIDTH + w.x;
        ch  = idx / DOTS;
        if (ch >= CHIPS) return;
        val = w.on ? lit_level : 8'h00;
        if (frame_q[ch * DOTS + idx % DOTS] == val) return;
        frame_q[ch * DOTS + idx % DOTS] = val;
        dirty_q[ch] = 1'b1;
        return;
      end
      MODE_CLEAR, MODE_FILL: begin
        val = (w.mode == MODE_FILL && w.on) ? lit_level : 8'h00;
        for (int i = 0; i < DEPTH; i++) frame_q[i] = val;
        for (int c = 0; c < CHIPS; c++) dirty_q[c] = 1'b1;
        return;
      end
      MODE_FLUSH: begin
        flush_armed = 1'b1;
        return;
      end
      MODE_BRIGHT: begin
        lit_level    = (w.level == 8'h00) ? 8'h01 : w.level;
        bright_lvl   = w.level;
        bright_armed = 1'b1;
        return;
      end
      MODE_NEXT_BYTE: ;
      default: return;
    endcase

    // start a pass when nothing runs: brightness goes first
    if (seq_ph == PH_IDLE) begin
      if (bright_armed) begin
        bright_armed = 1'b0;
        seq_ph  = PH_B_UNLOCK;
        seq_ch  = 0;
        seq_cnt = 0;
      end else if (flush_armed) begin
        flush_armed = 1'b0;
        start_dirty(0);
      end
      if (seq_ph == PH_IDLE) begin
        pending_bytes.push_back(IDLE_ANSWER);
        return;
      end
    end

    ch = seq_ch;
    case (seq_ph)
      PH_F_UNLOCK: begin
        done = pair_byte(BYTE_UNLOCK, BYTE_UNLOCK_KEY, r.out_byte, r.first, r.last);
        if (done) seq_ph = PH_F_PAGE;
      end
      PH_F_PAGE: begin
        done = pair_byte(BYTE_PAGE_CMD, BYTE_PAGE_PWM, r.out_byte, r.first, r.last);
        if (done) seq_ph = PH_F_DATA;
      end
      PH_F_DATA: begin
        if (seq_cnt == 0) begin
          r.out_byte = BYTE_PWM_START;
          r.first    = 1'b1;
          seq_cnt    = 1;
        end else begin
          // pwm bytes come from the store as it stands now
          r.out_byte = frame_q[ch * DOTS + seq_cnt - 1];
          pwm_bytes++;
          if (seq_cnt >= DOTS) begin
            r.last = 1'b1;
            start_dirty(ch + 1);
          end else begin
            seq_cnt++;
          end
        end
      end
      PH_B_UNLOCK: begin
        done = pair_byte(BYTE_UNLOCK, BYTE_UNLOCK_KEY, r.out_byte, r.first, r.last);
        if (done) seq_ph = PH_B_PAGE;
      end
      PH_B_PAGE: begin
        done = pair_byte(BYTE_PAGE_CMD, BYTE_PAGE_FUNC, r.out_byte, r.first, r.last);
        if (done) seq_ph = PH_B_CURR;
      end
      default: begin
        done = pair_byte(BYTE_CURRENT, bright_lvl, r.out_byte, r.first, r.last);
        if (done) begin
          if (ch + 1 < CHIPS) begin
            seq_ch = ch + 1;
            seq_ph = PH_B_UNLOCK;
          end else begin
            seq_ch = 0;
            seq_ph = PH_IDLE;
          end
        end
      end
    endcase
    r.chip_index = ch[1:0];
    pending_bytes.push_back(r);
  endfunction

  function automatic stim_row_t row(input logic [2:0] mode, input logic [7:0] x,
                                    input logic [7:0] y, input logic on,
                                    input logic [7:0] level, input logic typed,
                                    input out_t want);
    stim_row_t s;
    s.w.mode  = mode;
    s.w.x     = x;
    s.w.y     = y;
    s.w.on    = on;
    s.w.level = level;
    s.typed   = typed;
    s.want    = want;
    return s;
  endfunction

  function automatic out_t bus_byte(input logic [1:0] chip, input logic [7:0] b,
                                    input logic fst, input logic lst);
    return {1'b0, chip, b, fst, lst};
  endfunction

  // random word, mostly bus pulls and in-range pixels
  function automatic in_t random_word();
    in_t         w;
    int unsigned pick;
    w.mode  = MODE_NEXT_BYTE;
    w.x     = 8'($urandom_range(0, 255));
    w.y     = 8'($urandom_range(0, 255));
    w.on    = 1'($urandom_range(0, 1));
    w.level = 8'($urandom_range(0, 255));
    pick    = $urandom_range(0, 999);
    if (pick < 430) begin
      w.mode = MODE_NEXT_BYTE;
    end else if (pick < 700) begin
      w.mode = MODE_SET_PIXEL;
      w.x    = 8'($urandom_range(0, WIDTH - 1));
      w.y    = 8'($urandom_range(0, HEIGHT - 1));
    end else if (pick < 740) begin
      w.mode = MODE_SET_PIXEL;
    end else if (pick < 800) begin
      w.mode = MODE_FLUSH;
    end else if (pick < 830) begin
      w.mode = MODE_BRIGHT;
      // lean on the extremes of the level now and then
      if ($urandom_range(0, 3) == 0) w.level = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end else if (pick < 836) begin
      w.mode = MODE_CLEAR;
    end else if (pick < 842) begin
      w.mode = MODE_FILL;
    end else if (pick < 860) begin
      w.mode = $urandom_range(0, 1) ? MODE_SPARE_7 : MODE_SPARE_6;
    end
    return w;
  endfunction

  // offer one word, called at a falling edge and returns at one
  task automatic send_word(input in_t w, input logic typed, input out_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    apply_word(w);
    if (typed && w.mode == MODE_NEXT_BYTE) pending_bytes[pending_bytes.size() - 1] = want;
    words_sent++;
    @(negedge clk);
  endtask

  // compare one accepted bus byte with the oldest prediction
  task automatic check_byte(input out_t got);
    out_t want;
    bytes_seen++;
    if (got.idle) idle_seen++;
    if (pending_bytes.size() == 0) begin
      report($sformatf("unexpected byte %0d, data %h", bytes_seen, got));
      return;
    end
    want = pending_bytes.pop_front();
    if (got.idle !== want.idle)
      report($sformatf("byte %0d idle got %0d want %0d", bytes_seen, got.idle, want.idle));
    if (got.chip_index !== want.chip_index)
      report($sformatf("byte %0d chip_index got %0d want %0d", bytes_seen,
                       got.chip_index, want.chip_index));
    if (got.out_byte !== want.out_byte)
      report($sformatf("byte %0d out_byte got %h want %h", bytes_seen,
                       got.out_byte, want.out_byte));
    if (got.first !== want.first)
      report($sformatf("byte %0d first got %0d want %0d", bytes_seen, got.first, want.first));
    if (got.last !== want.last)
      report($sformatf("byte %0d last got %0d want %0d", bytes_seen, got.last, want.last));
  endtask

  // result side: sample at the rising edge, stall decided at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) check_byte(out_data);
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
             pending_bytes.size());
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    in_t w;
    int  counted;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // predicted state after reset
    for (int i = 0; i < DEPTH; i++) frame_q[i] = 8'h00;
    for (int c = 0; c < CHIPS; c++) dirty_q[c] = 1'b0;
    lit_level    = 8'hff;
    flush_armed  = 1'b0;
    bright_armed = 1'b0;
    bright_lvl   = 8'h00;
    seq_ph       = PH_IDLE;
    seq_ch       = 0;
    seq_cnt      = 0;

    // directed table
    // nothing pending after reset, then a flush with no dirty chip
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1, IDLE_ANSWER));
    stim_tab.push_back(row(MODE_FLUSH, 0, 0, 0, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1, IDLE_ANSWER));
    // zero brightness: on level goes to 1, current register still gets 0
    stim_tab.push_back(row(MODE_BRIGHT, 0, 0, 0, 8'h00, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1, bus_byte(0, BYTE_UNLOCK, 1, 0)));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1,
                           bus_byte(0, BYTE_UNLOCK_KEY, 0, 1)));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1, bus_byte(0, BYTE_PAGE_CMD, 1, 0)));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1, bus_byte(0, BYTE_PAGE_FUNC, 0, 1)));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1, bus_byte(0, BYTE_CURRENT, 1, 0)));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 1, bus_byte(0, 8'h00, 0, 1)));
    // corner pixels, out of range pixels and an unchanged pixel
    stim_tab.push_back(row(MODE_SET_PIXEL, 0, 0, 1, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_SET_PIXEL, 8'(WIDTH - 1), 8'(HEIGHT - 1), 1, 0, 0,
                           NO_ANSWER));
    stim_tab.push_back(row(MODE_SET_PIXEL, 8'(WIDTH), 0, 1, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_SET_PIXEL, 0, 8'(HEIGHT), 1, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_SET_PIXEL, 8'hff, 8'hff, 1, 8'hff, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_SET_PIXEL, 0, 0, 1, 0, 0, NO_ANSWER));
    // ignored modes
    stim_tab.push_back(row(MODE_SPARE_6, 8'hff, 8'hff, 1, 8'hff, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_SPARE_7, 8'h55, 8'haa, 0, 8'h5a, 0, NO_ANSWER));
    // full brightness while the brightness pass is still running
    stim_tab.push_back(row(MODE_BRIGHT, 0, 0, 0, 8'hff, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 0, NO_ANSWER));
    // arm a flush behind it, fill and clear the whole frame
    stim_tab.push_back(row(MODE_FLUSH, 0, 0, 0, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_FILL, 0, 0, 1, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_CLEAR, 0, 0, 0, 0, 0, NO_ANSWER));
    stim_tab.push_back(row(MODE_NEXT_BYTE, 0, 0, 0, 0, 0, NO_ANSWER));

    // reset, released at a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 20;
    rx_idle_pct = 77;
    foreach (stim_tab[i]) send_word(stim_tab[i].w, stim_tab[i].typed, stim_tab[i].want);

    // random words in three idling regimes
    counted = 0;
    for (int stage = 0; stage < 3; stage++) begin
      in_valid <= 1'b0;
      @(posedge clk);
      tx_idle_pct = (stage == 0) ? 20 : (stage == 1) ? 77 : 0;
      rx_idle_pct = (stage == 0) ? 77 : (stage == 1) ? 20 : 0;
      // long hold-off on the result side so the block backs up its input
      if (stage == 2) hold_left = LONG_HOLD;
      @(negedge clk);
      while (counted < (stage + 1) * N_RANDOM / 3) begin
        w = random_word();
        send_word(w, 1'b0, NO_ANSWER);
        if (w.mode != MODE_SPARE_6 && w.mode != MODE_SPARE_7) counted++;
      end
      // sender waits for every outstanding byte once
      if (stage == 0) begin
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for a sweep still in progress
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) report($sformatf("%0d bytes never arrived",
                                                    pending_bytes.size()));

    $display("summary: %0d words driven, %0d bus bytes checked, %0d idle answers,",
             words_sent, bytes_seen, idle_seen);
    $display("         %0d pwm data bytes predicted, %0d mismatches, %0d cycles",
             pwm_bytes, error_cnt, cycle_cnt);
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[led_matrix_frame_flusher.f]
+incdir+rtl
rtl/lmff_pkg.sv
rtl/lmff_ctrl.sv
rtl/lmff_dpath.sv
rtl/led_matrix_frame_flusher.sv
tb/tb.sv
